[sv/can_frame_base64_encoder_top_assert.svh]
// Assertion macros for the frame encoder
`ifndef CAN_FRAME_BASE64_ENCODER_TOP_ASSERT_SVH
`define CAN_FRAME_BASE64_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, reset masked
`define CFBE_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfbe assertion failed");

// next-cycle implication, reset masked
`define CFBE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfbe assertion failed");

`endif

[sv/cfbe_pkg.sv]
`timescale 1ns / 1ps
package cfbe_pkg;

  localparam int DATA_BYTES = 8;
  localparam int PAY_W      = 8 * DATA_BYTES;
  localparam int PACK_W     = 29 + PAY_W + 3;

  localparam logic [7:0] ALT_A_RST    = 8'h3F;
  localparam logic [7:0] ALT_PLUS_RST = 8'h40;
  localparam logic [7:0] CH_PAD       = 8'h3D;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_UPPER_A   = 8'h41;
  localparam logic [7:0] CH_LOWER_A   = 8'h61;
  localparam logic [7:0] CH_DIGIT_0   = 8'h30;

  typedef enum logic {
    CFG_ALT_A    = 1'b0,
    CFG_ALT_PLUS = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [PACK_W-1:0] bits;
    logic [7:0]        start_char;
    logic [4:0]        n_sext;
    logic [1:0]        n_pad;
  } frame_ent_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic [7:0] alt_a;
    logic [7:0] alt_plus;
  } alt_cfg_t;

  function automatic logic [7:0] start_sym(input logic ext, input logic [3:0] len);
    logic [7:0] c;
    if (!ext) begin
      unique case (len)
        4'd0:    c = 8'h20;
        4'd1:    c = 8'h21;
        4'd2:    c = 8'h22;
        4'd3:    c = 8'h23;
        4'd4:    c = 8'h24;
        4'd5:    c = 8'h25;
        4'd6:    c = 8'h26;
        4'd7:    c = 8'h27;
        default: c = 8'h28;
      endcase
    end else begin
      unique case (len)
        4'd0:    c = 8'h29;
        4'd1:    c = 8'h2A;
        4'd2:    c = 8'h2C;
        4'd3:    c = 8'h2D;
        4'd4:    c = 8'h2E;
        4'd5:    c = 8'h3A;
        4'd6:    c = 8'h3B;
        4'd7:    c = 8'h3C;
        default: c = 8'h3E;
      endcase
    end
    return c;
  endfunction

  function automatic logic [2:0] group_cnt(input logic [3:0] n);
    logic [2:0] g;
    unique case (n)
      4'd0:                    g = 3'd0;
      4'd1, 4'd2, 4'd3:        g = 3'd1;
      4'd4, 4'd5, 4'd6:        g = 3'd2;
      4'd7, 4'd8, 4'd9:        g = 3'd3;
      default:                 g = 3'd4;
    endcase
    return g;
  endfunction

  function automatic logic [1:0] pad_cnt(input logic [3:0] n);
    logic [1:0] p;
    unique case (n)
      4'd1, 4'd4, 4'd7, 4'd10: p = 2'd2;
      4'd2, 4'd5, 4'd8, 4'd11: p = 2'd1;
      default:                 p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v, input alt_cfg_t cfg);
    logic [7:0] c;
    if (v == 6'd0)       c = cfg.alt_a;
    else if (v < 6'd26)  c = CH_UPPER_A + {2'b00, v};
    else if (v < 6'd52)  c = CH_LOWER_A + {2'b00, 6'(v - 6'd26)};
    else if (v < 6'd62)  c = CH_DIGIT_0 + {2'b00, 6'(v - 6'd52)};
    else if (v == 6'd62) c = cfg.alt_plus;
    else                 c = CH_SLASH;
    return c;
  endfunction

endpackage

[sv/cfbe_front.sv]
`timescale 1ns / 1ps
module cfbe_front #(
  parameter int MAX_DATA_BYTES = 8
) (
  input  logic [28:0]          frame_id,
  input  logic                 is_extended,
  input  logic [3:0]           data_length,
  input  logic [7:0]           data_byte [cfbe_pkg::DATA_BYTES],
  output cfbe_pkg::frame_ent_t ent
);
  import cfbe_pkg::*;

  logic [3:0]       len_sat;
  logic [PAY_W-1:0] payload;
  logic [3:0]       n_bytes;
  logic [2:0]       n_grp;
  logic [1:0]       n_pad;

  always_comb begin
    len_sat = (data_length > 4'(MAX_DATA_BYTES)) ? 4'(MAX_DATA_BYTES) : data_length;
    for (int i = 0; i < DATA_BYTES; i++) begin
      payload[PAY_W-1-8*i -: 8] = (4'(i) < len_sat) ? data_byte[i] : 8'h00;
    end
    n_bytes = is_extended ? 4'd4 + len_sat : 4'd2 + len_sat;
    n_grp   = group_cnt(n_bytes);
    n_pad   = pad_cnt(n_bytes);

    if (is_extended) begin
      ent.bits = {frame_id, payload, {(PACK_W-29-PAY_W){1'b0}}};
    end else begin
      ent.bits = {frame_id[10:0], payload, {(PACK_W-11-PAY_W){1'b0}}};
    end
    ent.start_char = start_sym(is_extended, len_sat);
    ent.n_sext     = 5'({n_grp, 2'b00}) - 5'(n_pad);
    ent.n_pad      = n_pad;
  end

endmodule

[sv/cfbe_fifo.sv]
`timescale 1ns / 1ps
module cfbe_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  cfbe_pkg::frame_ent_t wr_ent,
  input  logic                 pop,
  output cfbe_pkg::frame_ent_t rd_ent,
  output cfbe_pkg::q_stat_t    stat
);
  import cfbe_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_ent_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign stat.empty = (cnt_r == CNT_W'(0));
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_ent     = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= CNT_W'(cnt_r + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_r <= CNT_W'(cnt_r - 1'b1);
      end
    end
  end

endmodule

[sv/cfbe_back.sv]
`timescale 1ns / 1ps
module cfbe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfbe_pkg::frame_ent_t q_rd,
  input  cfbe_pkg::q_stat_t    q_stat,
  output logic                 q_pop,
  input  cfbe_pkg::alt_cfg_t   cfg,
  output logic                 busy,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [7:0]           out_char,
  output logic                 out_last_char
);
  import cfbe_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEXT,
    ST_PAD
  } state_t;

  state_t            state_r;
  logic [PACK_W-1:0] bits_r;
  logic [4:0]        sext_r;
  logic [1:0]        pad_r;
  logic              out_valid_r;
  logic [7:0]        out_char_r;
  logic              out_last_r;
  logic              adv;

  assign adv           = !out_valid_r || out_pop;
  assign q_pop         = (state_r == ST_IDLE) && !q_stat.empty && adv;
  assign busy          = (state_r != ST_IDLE);
  assign out_empty     = !out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      unique case (state_r)
        ST_IDLE: begin
          if (!q_stat.empty) begin
            bits_r      <= q_rd.bits;
            sext_r      <= q_rd.n_sext;
            pad_r       <= q_rd.n_pad;
            out_char_r  <= q_rd.start_char;
            out_last_r  <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= ST_SEXT;
          end else begin
            out_valid_r <= 1'b0;
          end
        end
        ST_SEXT: begin
          out_char_r  <= sextet_char(bits_r[PACK_W-1 -: 6], cfg);
          out_last_r  <= (sext_r == 5'd1) && (pad_r == 2'd0);
          out_valid_r <= 1'b1;
          bits_r      <= bits_r << 6;
          sext_r      <= 5'(sext_r - 1'b1);
          if (sext_r == 5'd1) begin
            state_r <= (pad_r == 2'd0) ? ST_IDLE : ST_PAD;
          end
        end
        ST_PAD: begin
          out_char_r  <= CH_PAD;
          out_last_r  <= (pad_r == 2'd1);
          out_valid_r <= 1'b1;
          pad_r       <= 2'(pad_r - 1'b1);
          if (pad_r == 2'd1) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

[sv/can_frame_base64_encoder_top.sv]
`timescale 1ns / 1ps
// Channel   | Ports                                   | Word accepted when
// ----------+-----------------------------------------+---------------------------
// frame in  | in_frame_id .. in_data_byte7            | in_push && !in_full
// chars out | out_char, out_last_char                 | out_pop && !out_empty
// config    | cfg_we, cfg_index, cfg_wdata            | cfg_we
//
// A frame of n packed bytes (n = 2 + len standard, 4 + len extended) gives
// 1 + 4*ceil(n/3) characters, 5 to 17, one per cycle from the back sequencer while out_pop is high.
// A two-entry frame queue lets frames enter while the sequencer still works.
// Synchronous active-low reset; alternates reset to 0x3F and 0x40.
// A low out_pop holds the current character and stalls the sequencer.
module can_frame_base64_encoder_top #(
  parameter int MAX_DATA_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [28:0] in_frame_id,
  input  logic        in_is_extended,
  input  logic [3:0]  in_data_length,
  input  logic [7:0]  in_data_byte0,
  input  logic [7:0]  in_data_byte1,
  input  logic [7:0]  in_data_byte2,
  input  logic [7:0]  in_data_byte3,
  input  logic [7:0]  in_data_byte4,
  input  logic [7:0]  in_data_byte5,
  input  logic [7:0]  in_data_byte6,
  input  logic [7:0]  in_data_byte7,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_char,
  output logic        out_last_char,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import cfbe_pkg::*;

  logic [7:0] data_bytes [DATA_BYTES];
  frame_ent_t wr_ent;
  frame_ent_t q_rd;
  q_stat_t    q_stat;
  logic       q_pop;
  logic       back_busy;
  alt_cfg_t   cfg_r;

  assign data_bytes[0] = in_data_byte0;
  assign data_bytes[1] = in_data_byte1;
  assign data_bytes[2] = in_data_byte2;
  assign data_bytes[3] = in_data_byte3;
  assign data_bytes[4] = in_data_byte4;
  assign data_bytes[5] = in_data_byte5;
  assign data_bytes[6] = in_data_byte6;
  assign data_bytes[7] = in_data_byte7;
  assign in_full       = q_stat.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alt_a    <= ALT_A_RST;
      cfg_r.alt_plus <= ALT_PLUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ALT_A:    cfg_r.alt_a    <= cfg_wdata;
        CFG_ALT_PLUS: cfg_r.alt_plus <= cfg_wdata;
        default:      cfg_r          <= cfg_r;
      endcase
    end
  end

  cfbe_front #(
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_front (
    .frame_id   (in_frame_id),
    .is_extended(in_is_extended),
    .data_length(in_data_length),
    .data_byte  (data_bytes),
    .ent        (wr_ent)
  );

  cfbe_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wr_ent(wr_ent),
    .pop   (q_pop),
    .rd_ent(q_rd),
    .stat  (q_stat)
  );

  cfbe_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_rd         (q_rd),
    .q_stat       (q_stat),
    .q_pop        (q_pop),
    .cfg          (cfg_r),
    .busy         (back_busy),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_char     (out_char),
    .out_last_char(out_last_char)
  );

`include "can_frame_base64_encoder_top_assert.svh"

  `CFBE_ASSERT_IMPL(a_pop_needs_entry, q_pop, !q_stat.empty)
  `CFBE_ASSERT_NEXT(a_start_char_follows, q_pop, !out_empty && out_char == $past(q_rd.start_char))
  `CFBE_ASSERT_IMPL(a_last_means_idle, !out_empty && out_last_char, !back_busy)

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import cfbe_pkg::*;

  localparam int MAX_LEN = 8;
  localparam logic [7:0] LEAD_STD [0:8] = '{8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
                                            8'h25, 8'h26, 8'h27, 8'h28};
  localparam logic [7:0] LEAD_EXT [0:8] = '{8'h29, 8'h2A, 8'h2C, 8'h2D, 8'h2E,
                                            8'h3A, 8'h3B, 8'h3C, 8'h3E};

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  typedef struct {
    logic [28:0] id;
    logic        ext;
    logic [3:0]  len;
    logic [63:0] data;
    string       text;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [28:0] in_frame_id = '0;
  logic        in_is_extended = 1'b0;
  logic [3:0]  in_data_length = '0;
  logic [7:0]  in_data_byte0 = '0;
  logic [7:0]  in_data_byte1 = '0;
  logic [7:0]  in_data_byte2 = '0;
  logic [7:0]  in_data_byte3 = '0;
  logic [7:0]  in_data_byte4 = '0;
  logic [7:0]  in_data_byte5 = '0;
  logic [7:0]  in_data_byte6 = '0;
  logic [7:0]  in_data_byte7 = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_char;
  logic        out_last_char;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  char_word_t  expected_chars [$];
  logic [7:0]  alt_a_now = ALT_A_RST;
  logic [7:0]  alt_plus_now = ALT_PLUS_RST;
  int          mismatch_count = 0;
  bit          gaps_on = 1'b0;
  int          burst_left = 0;

  logic [1:0]  pop_mode = 2'd0;
  int          pop_hold = 0;
  logic [7:0]  pop_pattern = 8'hA5;
  logic [2:0]  pop_phase = 3'd0;

  // byte i of the payload sits at data[8*i +: 8]
  frame_row_t directed_rows [25] = '{
    '{29'h0000000, 1'b0, 4'd0,  64'h0,                 " ???="},
    '{29'h00007FF, 1'b0, 4'd0,  64'h0,                 " /@?="},
    '{29'h0000000, 1'b1, 4'd0,  64'h0,                 ")??????=="},
    '{29'h1FFFF800, 1'b0, 4'd0, 64'hFFFFFFFFFFFFFFFF,  " ???="},
    '{29'h1FFFFFFF, 1'b1, 4'd0, 64'h0,                 ""},
    '{29'h1FFFFFFF, 1'b1, 4'd8, 64'hFFFFFFFFFFFFFFFF,  ""},
    '{29'h00007FF, 1'b0, 4'd8,  64'hFFFFFFFFFFFFFFFF,  ""},
    '{29'h0000000, 1'b0, 4'd8,  64'h0,                 ""},
    '{29'h0000000, 1'b1, 4'd8,  64'h0,                 ""},
    '{29'h00005A5, 1'b0, 4'd1,  64'h0123456789ABCDEF,  ""},
    '{29'h00005A5, 1'b0, 4'd2,  64'h0123456789ABCDEF,  ""},
    '{29'h00005A5, 1'b0, 4'd3,  64'h0123456789ABCDEF,  ""},
    '{29'h00005A5, 1'b0, 4'd4,  64'h0123456789ABCDEF,  ""},
    '{29'h00005A5, 1'b0, 4'd5,  64'h0123456789ABCDEF,  ""},
    '{29'h00005A5, 1'b0, 4'd6,  64'h0123456789ABCDEF,  ""},
    '{29'h00005A5, 1'b0, 4'd7,  64'h0123456789ABCDEF,  ""},
    '{29'h15555555, 1'b1, 4'd1, 64'hFEDCBA9876543210,  ""},
    '{29'h0AAAAAAA, 1'b1, 4'd2, 64'hFEDCBA9876543210,  ""},
    '{29'h15555555, 1'b1, 4'd3, 64'hFEDCBA9876543210,  ""},
    '{29'h0AAAAAAA, 1'b1, 4'd4, 64'hFEDCBA9876543210,  ""},
    '{29'h15555555, 1'b1, 4'd5, 64'hFEDCBA9876543210,  ""},
    '{29'h0AAAAAAA, 1'b1, 4'd6, 64'hFEDCBA9876543210,  ""},
    '{29'h15555555, 1'b1, 4'd7, 64'hFEDCBA9876543210,  ""},
    '{29'h00003C3, 1'b0, 4'd9,  64'h8040201008040201,  ""},
    '{29'h12345678, 1'b1, 4'hF, 64'hC3A55A3C0FF01E2D,  ""}
  };

  can_frame_base64_encoder_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_frame_id    (in_frame_id),
    .in_is_extended (in_is_extended),
    .in_data_length (in_data_length),
    .in_data_byte0  (in_data_byte0),
    .in_data_byte1  (in_data_byte1),
    .in_data_byte2  (in_data_byte2),
    .in_data_byte3  (in_data_byte3),
    .in_data_byte4  (in_data_byte4),
    .in_data_byte5  (in_data_byte5),
    .in_data_byte6  (in_data_byte6),
    .in_data_byte7  (in_data_byte7),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_char       (out_char),
    .out_last_char  (out_last_char),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    if (v == 6'd0) return alt_a_now;
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
    if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
    if (v == 6'd62) return alt_plus_now;
    return 8'h2F;
  endfunction

  function automatic void encode_frame_chars(input logic [28:0] id, input logic ext,
                                             input logic [3:0] len_in,
                                             input logic [63:0] data);
    logic [95:0] bits;
    logic [23:0] grp;
    int          len;
    int          pos;
    int          nbytes;
    int          left;
    bits = '0;
    len = (len_in > MAX_LEN) ? MAX_LEN : int'(len_in);
    if (ext) begin
      bits[95:67] = id;
      pos = 67;
      nbytes = 4 + len;
      expected_chars.push_back('{LEAD_EXT[len], 1'b0});
    end else begin
      bits[95:85] = id[10:0];
      pos = 85;
      nbytes = 2 + len;
      expected_chars.push_back('{LEAD_STD[len], 1'b0});
    end
    for (int i = 0; i < len; i++) begin
      bits[pos-1 -: 8] = data[8*i +: 8];
      pos -= 8;
    end
    for (int g = 0; 3 * g < nbytes; g++) begin
      grp = bits[95 - 24*g -: 24];
      left = nbytes - 3 * g;
      expected_chars.push_back('{b64_symbol(grp[23:18]), 1'b0});
      expected_chars.push_back('{b64_symbol(grp[17:12]), 1'b0});
      expected_chars.push_back('{(left >= 2) ? b64_symbol(grp[11:6]) : CH_PAD, 1'b0});
      expected_chars.push_back('{(left >= 3) ? b64_symbol(grp[5:0]) : CH_PAD, 1'b0});
    end
    expected_chars[$].last = 1'b1;
  endfunction

  task automatic send_frame(input logic [28:0] id, input logic ext, input logic [3:0] len,
                            input logic [63:0] data, input string text);
    in_frame_id    <= id;
    in_is_extended <= ext;
    in_data_length <= len;
    in_data_byte0  <= data[7:0];
    in_data_byte1  <= data[15:8];
    in_data_byte2  <= data[23:16];
    in_data_byte3  <= data[31:24];
    in_data_byte4  <= data[39:32];
    in_data_byte5  <= data[47:40];
    in_data_byte6  <= data[55:48];
    in_data_byte7  <= data[63:56];
    in_push        <= 1'b1;
    do @(posedge clk); while (in_full);
    if (text.len() == 0) begin
      encode_frame_chars(id, ext, len, data);
    end else begin
      for (int i = 0; i < text.len(); i++)
        expected_chars.push_back('{8'(text[i]), i == text.len() - 1});
    end
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        burst_left = $urandom_range(1, 6);
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_frame();
    logic [63:0] data;
    logic [28:0] id;
    logic [3:0]  len;
    for (int i = 0; i < 8; i++) data[8*i +: 8] = random_byte();
    id = ($urandom_range(0, 9) == 0) ? 29'h0 : 29'($urandom);
    len = ($urandom_range(0, 6) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    send_frame(id, 1'($urandom), len, data, "");
  endtask

  task automatic set_alternates(input logic [7:0] alt_a, input logic [7:0] alt_plus);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ALT_A;
    cfg_wdata <= alt_a;
    @(posedge clk);
    cfg_index <= CFG_ALT_PLUS;
    cfg_wdata <= alt_plus;
    @(posedge clk);
    cfg_we <= 1'b0;
    alt_a_now = alt_a;
    alt_plus_now = alt_plus;
  endtask

  task automatic wait_idle();
    in_push <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    char_word_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_chars.size() == 0) begin
        $error("out_char %h arrived with no frame pending", out_char);
        mismatch_count++;
      end else begin
        want = expected_chars.pop_front();
        if (out_char !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, out_char);
          mismatch_count++;
        end
        if (out_last_char !== want.last) begin
          $error("out_last_char: expected %b, got %b", want.last, out_last_char);
          mismatch_count++;
        end
      end
    end
    if (pop_hold == 0) begin
      pop_mode    <= 2'($urandom_range(0, 3));
      pop_hold    <= $urandom_range(20, 80);
      pop_pattern <= 8'($urandom) | 8'h01;
    end else begin
      pop_hold <= pop_hold - 1;
    end
    pop_phase <= pop_phase + 3'd1;
    case (pop_mode)
      2'd0: out_pop <= 1'b1;
      2'd1: out_pop <= 1'($urandom);
      2'd2: out_pop <= ($urandom_range(0, 3) == 0);
      default: out_pop <= pop_pattern[pop_phase];
    endcase
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gaps_on = 1'b1;
    foreach (directed_rows[r])
      send_frame(directed_rows[r].id, directed_rows[r].ext, directed_rows[r].len,
                 directed_rows[r].data, directed_rows[r].text);
    wait_idle();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_alternates(8'h00, 8'hFF);
        1: set_alternates(8'hFF, 8'h00);
        2: set_alternates(8'($urandom), 8'($urandom));
        default: set_alternates(8'h41, 8'h2B);
      endcase
      gaps_on = (phase != 0);
      repeat (34) send_random_frame();
      wait_idle();
    end
    repeat (20) @(posedge clk);
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/cfbe_pkg.sv
sv/cfbe_front.sv
sv/cfbe_fifo.sv
sv/cfbe_back.sv
sv/can_frame_base64_encoder_top.sv
bench/testbench.sv
